FILE: rtl/trade_record_csv_parser_assert.svh
// assertion macros for the trade record parser
`ifndef TRADE_RECORD_CSV_PARSER_ASSERT_SVH
`define TRADE_RECORD_CSV_PARSER_ASSERT_SVH
// implication checked every cycle outside reset
`define TRCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication checked in the cycle after the antecedent
`define TRCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/trcp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trcp_pkg
// shared types and constants of the trade record parser
// ---------------------------------------------------------------------------
package trcp_pkg;
   localparam logic [3:0] ERR_NONE    = 4'd0;
   localparam logic [3:0] ERR_COUNT   = 4'd1;
   localparam logic [3:0] ERR_ID      = 4'd2;
   localparam logic [3:0] ERR_ACCOUNT = 4'd3;
   localparam logic [3:0] ERR_SYMBOL  = 4'd4;
   localparam logic [3:0] ERR_SIDE    = 4'd5;
   localparam logic [3:0] ERR_QTY     = 4'd6;
   localparam logic [3:0] ERR_PRICE   = 4'd7;
   localparam logic [3:0] ERR_TIME    = 4'd8;
   localparam logic [49:0] WHOLE_CEILING = 50'd922337203685477;
   localparam logic [49:0] MAX_WHOLE_RESET = 50'd100000000;
   localparam logic [2:0] LAST_FIELD = 3'd6;

   // one classified line byte from the front end
   typedef struct packed {
      logic       has_byte;
      logic [7:0] char_byte;
      logic       end_of_line;
   } item_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [63:0] event_id;
      logic        sell_side;
      logic [63:0] quantity;
      logic [62:0] scaled_price;
      logic [63:0] timestamp;
      logic [11:0] account_start;
      logic [11:0] account_length;
      logic [11:0] symbol_start;
      logic [11:0] symbol_length;
   } result_type;
endpackage

FILE: rtl/trcp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trcp_queue
// two-entry queue between byte intake and field parsing
// ---------------------------------------------------------------------------
module trcp_queue import trcp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_stall,
   input  item_type wr_data,
   output logic     rd_valid,
   input  logic     rd_stall,
   output item_type rd_data
);
   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_stall = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push = wr_valid & ~wr_stall;
   assign pop  = rd_valid & ~rd_stall;
   assign wptr_in  = push ? ~wptr_ff : wptr_ff;
   assign rptr_in  = pop ? ~rptr_ff : rptr_ff;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_data;
   end
endmodule

FILE: rtl/trcp_parse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trcp_parse
// per-byte field parser with registered result stage
// ---------------------------------------------------------------------------
module trcp_parse import trcp_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [49:0] max_whole,
   input  logic        in_valid,
   output logic        in_stall,
   input  item_type    in_data,
   output logic        out_valid,
   input  logic        out_stall,
   output result_type  out_data
);
`include "trade_record_csv_parser_assert.svh"
   localparam int PW = $clog2(MAX_LINE);
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_LINE - 1);

   logic [2:0]    fnum_ff, fnum_in;
   logic          extra_ff, extra_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [1:0]    phase_ff, phase_in;
   logic [63:0]   acc_ff, acc_in;
   logic          neg_ff, neg_in, dseen_ff, dseen_in, bad_ff, bad_in;
   logic          pt_ff, pt_in, gap_ff, gap_in, fds_ff, fds_in, fblk_ff, fblk_in;
   logic [2:0]    fcnt_ff, fcnt_in;
   logic [13:0]   facc_ff, facc_in;
   logic [2:0]    side_ff, side_in;
   logic [PW-1:0] sfirst_ff, sfirst_in, slast_ff, slast_in;
   logic [63:0]   id_ff, id_in, qty_ff, qty_in;
   logic [62:0]   price_ff, price_in;
   logic          sell_ff, sell_in;
   logic [11:0]   as_ff, as_in, al_ff, al_in, ss_ff, ss_in, sl_ff, sl_in;
   logic [3:0]    ferr_ff, ferr_in;
   logic          ov_ff;
   result_type    res_ff, res_in;
   logic          take, emit;

   logic [49:0]  lim;
   logic [7:0]   c;
   logic         fblank, blank, isdig, comma, closing, ok;
   logic [3:0]   dval;
   logic [63:0]  ilim, facc_sc, negacc;
   logic [67:0]  acc10, pnext;
   logic [PW:0]  slen;
   logic [63:0]  pfull;

   assign lim  = (max_whole > WHOLE_CEILING) ? WHOLE_CEILING : max_whole;
   assign take = in_valid & ~in_stall;
   assign in_stall = ov_ff & out_stall;
   assign out_valid = ov_ff;
   assign out_data  = res_ff;
   assign c      = in_data.char_byte;
   assign fblank = (c == 8'h20) || (c == 8'h09);
   assign blank  = fblank || (c == 8'h0d);
   assign isdig  = (c >= 8'h30) && (c <= 8'h39);
   assign dval   = c[3:0];
   assign comma  = (c == 8'h2c);
   // full-width times ten plus digit, compared against the field limit
   assign acc10  = {1'b0, acc_ff, 3'b0} + {3'b0, acc_ff, 1'b0};
   assign pnext  = acc10 + {64'b0, dval};
   assign ilim   = (fnum_ff == 3'd0) ? '1 : (neg_ff ? 64'h8000000000000000
                                                    : 64'h7fffffffffffffff);
   assign negacc = neg_ff ? (64'd0 - acc_ff) : acc_ff;
   assign slen   = {1'b0, slast_ff} - {1'b0, sfirst_ff} + 1'b1;
   // fraction scaled up to four digits
   always_comb begin
      facc_sc = 64'd0;
      if (fds_ff) begin
         unique case (fcnt_ff)
            3'd1:    facc_sc = 64'(facc_ff) * 64'd1000;
            3'd2:    facc_sc = 64'(facc_ff) * 64'd100;
            3'd3:    facc_sc = 64'(facc_ff) * 64'd10;
            default: facc_sc = 64'(facc_ff);
         endcase
      end
   end
   assign pfull = acc_ff * 64'd10000 + facc_sc;

   function automatic logic [11:0] sat12(input logic [PW:0] v);
      sat12 = (v > (PW+1)'(4095)) ? 12'd4095 : 12'(v);
   endfunction

   // field close and per-byte update
   always_comb begin
      fnum_in = fnum_ff; extra_in = extra_ff; pos_in = pos_ff; phase_in = phase_ff;
      acc_in = acc_ff; neg_in = neg_ff; dseen_in = dseen_ff; bad_in = bad_ff;
      pt_in = pt_ff; gap_in = gap_ff; fds_in = fds_ff; fblk_in = fblk_ff;
      fcnt_in = fcnt_ff; facc_in = facc_ff; side_in = side_ff;
      sfirst_in = sfirst_ff; slast_in = slast_ff;
      id_in = id_ff; qty_in = qty_ff; price_in = price_ff;
      sell_in = sell_ff; as_in = as_ff; al_in = al_ff; ss_in = ss_ff; sl_in = sl_ff;
      ferr_in = ferr_ff; res_in = res_ff; emit = 1'b0;
      closing = 1'b0;
      ok = ~bad_ff & dseen_ff;
      if (take && in_data.has_byte && comma && fnum_ff < LAST_FIELD) closing = 1'b1;
      if (closing) begin
         unique case (fnum_ff)
            3'd0: id_in = acc_ff;
            3'd1, 3'd2: begin
               ok = (phase_ff == 2'd2);
               if (fnum_ff == 3'd1) begin
                  as_in = sat12({1'b0, sfirst_ff}); al_in = sat12(slen);
               end else begin
                  ss_in = sat12({1'b0, sfirst_ff}); sl_in = sat12(slen);
               end
            end
            3'd3: begin
               ok = ~bad_ff & (side_ff == 3'd3 || side_ff == 3'd7);
               sell_in = (side_ff == 3'd7);
            end
            3'd4: qty_in = negacc;
            3'd5: begin
               if (acc_ff == 64'(lim) && facc_sc != 64'd0) ok = 1'b0;
               price_in = pfull[62:0];
            end
            default: ;
         endcase
         if (!ok && ferr_in == ERR_NONE) ferr_in = {1'b0, fnum_ff} + 4'd2;
         fnum_in = fnum_ff + 3'd1;
         phase_in = 2'd0; acc_in = '0; neg_in = 0; dseen_in = 0; bad_in = 0;
         pt_in = 0; fcnt_in = '0; facc_in = '0; side_in = '0;
         sfirst_in = '0; slast_in = '0; gap_in = 0; fds_in = 0; fblk_in = 0;
      end else if (take && in_data.has_byte && comma) begin
         extra_in = 1'b1;
      end else if (take && in_data.has_byte && !extra_ff
                   && !(phase_ff == 2'd0 && fblank)) begin
         if (phase_ff == 2'd0) sfirst_in = pos_ff;
         if (!blank) begin
            phase_in = 2'd2; slast_in = pos_ff;
         end else if (phase_ff == 2'd0) begin
            phase_in = 2'd1;
         end
         unique case (fnum_ff)
            3'd0, 3'd4, 3'd6: begin
               if (blank) gap_in = 1'b1;
               else if (gap_ff) bad_in = 1'b1;
               else if (isdig) begin
                  if (pnext > {4'b0, ilim}) bad_in = 1'b1;
                  else acc_in = pnext[63:0];
                  dseen_in = 1'b1;
               end else if (c == 8'h2d && fnum_ff != 3'd0 && !dseen_ff && !neg_ff)
                  neg_in = 1'b1;
               else bad_in = 1'b1;
            end
            3'd3: begin
               if (blank) gap_in = 1'b1;
               else if (gap_ff) bad_in = 1'b1;
               else begin
                  priority if (side_ff == 3'd0 && c == 8'h42) side_in = 3'd1;
                  else if (side_ff == 3'd0 && c == 8'h53) side_in = 3'd4;
                  else if (side_ff == 3'd1 && c == 8'h55) side_in = 3'd2;
                  else if (side_ff == 3'd2 && c == 8'h59) side_in = 3'd3;
                  else if (side_ff == 3'd4 && c == 8'h45) side_in = 3'd5;
                  else if (side_ff == 3'd5 && c == 8'h4c) side_in = 3'd6;
                  else if (side_ff == 3'd6 && c == 8'h4c) side_in = 3'd7;
                  else bad_in = 1'b1;
               end
            end
            3'd5: begin
               if (blank) begin
                  if (!pt_ff || fds_ff) gap_in = 1'b1;
                  else begin
                     if (fcnt_ff < 3'd7) fcnt_in = fcnt_ff + 3'd1;
                     if (c == 8'h0d) fblk_in = 1'b1;
                  end
               end else if (!pt_ff) begin
                  if (isdig) begin
                     if (gap_ff) bad_in = 1'b1;
                     else begin
                        if (pnext > 68'(lim)) bad_in = 1'b1;
                        else acc_in = pnext[63:0];
                        dseen_in = 1'b1;
                     end
                  end else if (c == 8'h2e) begin
                     if (!dseen_ff) bad_in = 1'b1;
                     pt_in = 1'b1; gap_in = 1'b0;
                  end else bad_in = 1'b1;
               end else if (isdig) begin
                  if (gap_ff || fblk_ff || fcnt_ff >= 3'd4) bad_in = 1'b1;
                  else begin
                     fcnt_in = fcnt_ff + 3'd1;
                     facc_in = 14'({facc_ff, 3'b0} + {facc_ff, 1'b0}) + 14'(dval);
                     fds_in = 1'b1;
                  end
               end else bad_in = 1'b1;
            end
            default: ;
         endcase
      end
      if (take && in_data.has_byte && pos_ff < POS_MAX) pos_in = pos_ff + 1'b1;
      if (take && in_data.end_of_line) begin
         emit = 1'b1;
         res_in = '0;
         // the last byte is folded in first, then the timestamp field closes
         if (fnum_in == LAST_FIELD && !extra_in) begin
            res_in.error_code = ferr_in;
            if (ferr_in == ERR_NONE && (bad_in || !dseen_in)) res_in.error_code = ERR_TIME;
         end else res_in.error_code = ERR_COUNT;
         if (res_in.error_code == ERR_NONE) begin
            res_in.event_id = id_in; res_in.sell_side = sell_in;
            res_in.quantity = qty_in; res_in.scaled_price = price_in;
            res_in.timestamp = neg_in ? (64'd0 - acc_in) : acc_in;
            res_in.account_start = as_in; res_in.account_length = al_in;
            res_in.symbol_start = ss_in; res_in.symbol_length = sl_in;
         end
         // start of a new line
         fnum_in = '0; extra_in = 0; pos_in = '0; phase_in = '0; acc_in = '0;
         neg_in = 0; dseen_in = 0; bad_in = 0; pt_in = 0; fcnt_in = '0; facc_in = '0;
         side_in = '0; sfirst_in = '0; slast_in = '0; gap_in = 0; fds_in = 0;
         fblk_in = 0; id_in = '0; qty_in = '0; price_in = '0;
         sell_in = 0; as_in = '0; al_in = '0; ss_in = '0; sl_in = '0; ferr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fnum_ff <= '0; extra_ff <= 0; pos_ff <= '0; phase_ff <= '0; acc_ff <= '0;
         neg_ff <= 0; dseen_ff <= 0; bad_ff <= 0; pt_ff <= 0; fcnt_ff <= '0;
         facc_ff <= '0; side_ff <= '0; sfirst_ff <= '0; slast_ff <= '0; gap_ff <= 0;
         fds_ff <= 0; fblk_ff <= 0; id_ff <= '0; qty_ff <= '0;
         price_ff <= '0; sell_ff <= 0; as_ff <= '0; al_ff <= '0; ss_ff <= '0;
         sl_ff <= '0; ferr_ff <= '0; ov_ff <= 1'b0;
      end else begin
         fnum_ff <= fnum_in; extra_ff <= extra_in; pos_ff <= pos_in;
         phase_ff <= phase_in; acc_ff <= acc_in; neg_ff <= neg_in;
         dseen_ff <= dseen_in; bad_ff <= bad_in; pt_ff <= pt_in; fcnt_ff <= fcnt_in;
         facc_ff <= facc_in; side_ff <= side_in; sfirst_ff <= sfirst_in;
         slast_ff <= slast_in; gap_ff <= gap_in; fds_ff <= fds_in; fblk_ff <= fblk_in;
         id_ff <= id_in; qty_ff <= qty_in; price_ff <= price_in;
         sell_ff <= sell_in; as_ff <= as_in; al_ff <= al_in; ss_ff <= ss_in;
         sl_ff <= sl_in; ferr_ff <= ferr_in;
         if (emit) ov_ff <= 1'b1;
         else if (!out_stall) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) res_ff <= res_in;
   end

   `TRCP_ASSERT_IMP(a_fnum_range, clock, reset, 1'b1, fnum_ff <= LAST_FIELD, "field number past last")
   `TRCP_ASSERT_NEXT(a_result_holds, clock, reset, ov_ff && out_stall, ov_ff && $stable(res_ff), "stalled result lost")
   `TRCP_ASSERT_NEXT(a_line_restart, clock, reset, emit, fnum_ff == 3'd0 && pos_ff == '0, "line state not cleared")
endmodule

FILE: rtl/trade_record_csv_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trade_record_csv_parser
// byte-serial parser of seven-field comma-separated trade lines
// ---------------------------------------------------------------------------
// usage
// - req_ channel: one line byte per transfer (req_has_byte, req_char_byte),
//   req_end_of_line marks the last transfer of a line; has_byte low with
//   end_of_line high is an empty line
// - rsp_ channel: one record per line, produced by the end-of-line transfer
// - csr_ port: write max_whole_units at any idle time, no read-back
// throughput: one byte per cycle while no record is stalled on rsp_, set by the per-byte times-ten accumulate
// record path: the end-of-line transfer is written into a queue entry, then
//   the parser update moves the record into the result register, which
//   drives rsp_valid
// reset: synchronous, clears line state, queue and result valid; limit
//   returns to 100000000
// rsp stall: the result register holds and the parser stops taking bytes;
//   the two-entry queue then fills and req_stall rises
// ---------------------------------------------------------------------------
module trade_record_csv_parser import trcp_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_has_byte,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_line,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_error_code,
   output logic [63:0] rsp_event_id,
   output logic        rsp_sell_side,
   output logic signed [63:0] rsp_quantity,
   output logic [62:0] rsp_scaled_price,
   output logic signed [63:0] rsp_timestamp,
   output logic [11:0] rsp_account_start,
   output logic [11:0] rsp_account_length,
   output logic [11:0] rsp_symbol_start,
   output logic [11:0] rsp_symbol_length,
   input  logic        csr_write,
   input  logic [49:0] csr_wdata
);
   logic [49:0] max_whole_ff;
   item_type    wr_item, rd_item;
   logic        q_valid, q_stall;
   result_type  res;

   // price limit register
   always_ff @(posedge clock) begin
      if (reset) max_whole_ff <= MAX_WHOLE_RESET;
      else if (csr_write) max_whole_ff <= csr_wdata;
   end

   assign wr_item = '{has_byte: req_has_byte, char_byte: req_char_byte,
                      end_of_line: req_end_of_line};

   // front: decouples the byte feed from field parsing
   trcp_queue u_queue (
      .clock, .reset,
      .wr_valid(req_valid), .wr_stall(req_stall), .wr_data(wr_item),
      .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(rd_item)
   );

   // back: field state machine and result register
   trcp_parse #(.MAX_LINE(MAX_LINE)) u_parse (
      .clock, .reset, .max_whole(max_whole_ff),
      .in_valid(q_valid), .in_stall(q_stall), .in_data(rd_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(res)
   );

   assign rsp_error_code     = res.error_code;
   assign rsp_event_id       = res.event_id;
   assign rsp_sell_side      = res.sell_side;
   assign rsp_quantity       = res.quantity;
   assign rsp_scaled_price   = res.scaled_price;
   assign rsp_timestamp      = res.timestamp;
   assign rsp_account_start  = res.account_start;
   assign rsp_account_length = res.account_length;
   assign rsp_symbol_start   = res.symbol_start;
   assign rsp_symbol_length  = res.symbol_length;
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// line-level test of the trade record csv parser
// ---------------------------------------------------------------------------
// trade lines are sent one byte per transfer, most of them well formed with
// random field content, the rest broken or noise. a behavioral copy of the
// parser predicts each record, and every record transfer is compared field
// by field against the oldest prediction. the price limit register is
// swept through its extremes between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
   import trcp_pkg::*;

   localparam int CLOCK_CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES      = 10;
   localparam int RANDOM_ITEMS      = 200;
   localparam int POS_MAX           = 4095;

   // characters the parser cares about
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // phase of the current field
   localparam int PH_LEAD = 0;   // only leading blanks so far
   localparam int PH_CR   = 1;   // started with a carriage return
   localparam int PH_TEXT = 2;   // real text seen

   // BUY / SELL matcher states
   localparam int SM_START = 0;
   localparam int SM_B     = 1;
   localparam int SM_BU    = 2;
   localparam int SM_BUY   = 3;
   localparam int SM_S     = 4;
   localparam int SM_SE    = 5;
   localparam int SM_SEL   = 6;
   localparam int SM_SELL  = 7;
   localparam int SM_BAD   = 8;

   localparam int F_ID = 0, F_ACCOUNT = 1, F_SYMBOL = 2, F_SIDE = 3;
   localparam int F_QTY = 4, F_PRICE = 5, F_TIME = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_has_byte = 1'b0;
   logic [7:0]  req_char_byte = 8'd0;
   logic        req_end_of_line = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_error_code;
   logic [63:0] rsp_event_id;
   logic        rsp_sell_side;
   logic signed [63:0] rsp_quantity;
   logic [62:0] rsp_scaled_price;
   logic signed [63:0] rsp_timestamp;
   logic [11:0] rsp_account_start;
   logic [11:0] rsp_account_length;
   logic [11:0] rsp_symbol_start;
   logic [11:0] rsp_symbol_length;
   logic        csr_write = 1'b0;
   logic [49:0] csr_wdata = '0;

   trade_record_csv_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_has_byte       (req_has_byte),
      .req_char_byte      (req_char_byte),
      .req_end_of_line    (req_end_of_line),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_error_code     (rsp_error_code),
      .rsp_event_id       (rsp_event_id),
      .rsp_sell_side      (rsp_sell_side),
      .rsp_quantity       (rsp_quantity),
      .rsp_scaled_price   (rsp_scaled_price),
      .rsp_timestamp      (rsp_timestamp),
      .rsp_account_start  (rsp_account_start),
      .rsp_account_length (rsp_account_length),
      .rsp_symbol_start   (rsp_symbol_start),
      .rsp_symbol_length  (rsp_symbol_length),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata)
   );

   // records predicted but not yet seen on the rsp side
   result_type pending_records[$];
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  records_seen   = 0;
   bit  quiet          = 1'b0;   // no idling on either side while set

   // ------------------------------------------------------------------------
   // parser state, mirrors the block
   // ------------------------------------------------------------------------
   logic [49:0] whole_limit_reg;
   int unsigned field_idx;
   bit          past_last_comma;
   int unsigned line_pos;
   int unsigned phase;
   logic [63:0] num_acc;
   bit          num_neg, saw_digit, field_broken, saw_point;
   bit          saw_gap, saw_frac_digit, frac_blocked, line_sell;
   int unsigned frac_count;
   int unsigned frac_acc;
   int unsigned side_state;
   int unsigned text_first, text_last;
   logic [63:0] id_val, qty_val, price_val, time_val;
   int unsigned name_first[2], name_len[2];
   logic [3:0]  line_error;

   function void clear_field_state();
      phase = PH_LEAD;
      num_acc = '0;
      num_neg = 0; saw_digit = 0; field_broken = 0; saw_point = 0;
      frac_count = 0; frac_acc = 0;
      side_state = SM_START;
      text_first = 0; text_last = 0;
      saw_gap = 0; saw_frac_digit = 0; frac_blocked = 0;
   endfunction

   function void clear_line_state();
      clear_field_state();
      field_idx = 0;
      past_last_comma = 0;
      line_pos = 0;
      id_val = '0; qty_val = '0; price_val = '0; time_val = '0;
      line_error = ERR_NONE;
      line_sell = 0;
      name_first = '{0, 0};
      name_len   = '{0, 0};
   endfunction

   function logic [63:0] effective_limit();
      return (whole_limit_reg > WHOLE_CEILING) ? 64'(WHOLE_CEILING)
                                              : 64'(whole_limit_reg);
   endfunction

   function logic [3:0] error_of_field(int unsigned f);
      case (f)
         F_ID:      return ERR_ID;
         F_ACCOUNT: return ERR_ACCOUNT;
         F_SYMBOL:  return ERR_SYMBOL;
         F_SIDE:    return ERR_SIDE;
         F_QTY:     return ERR_QTY;
         F_PRICE:   return ERR_PRICE;
         default:   return ERR_TIME;
      endcase
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function void take_integer_char(logic [7:0] c, bit signed_field, bit blank);
      logic [63:0] d, lim;
      if (blank) begin
         saw_gap = 1;
      end else if (saw_gap) begin
         field_broken = 1;
      end else if (is_digit(c)) begin
         d = 64'(c - CH_ZERO);
         lim = !signed_field ? 64'hFFFF_FFFF_FFFF_FFFF :
               (num_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
         if (num_acc > (lim - d) / 10) field_broken = 1;
         else num_acc = num_acc * 10 + d;
         saw_digit = 1;
      end else if (c == CH_MINUS && signed_field && !saw_digit && !num_neg) begin
         num_neg = 1;
      end else begin
         field_broken = 1;
      end
   endfunction

   function void take_price_char(logic [7:0] c, bit blank);
      logic [63:0] next_acc;
      if (blank) begin
         if (!saw_point || saw_frac_digit) begin
            saw_gap = 1;
         end else begin
            // blanks at the front of the fraction count as digit places
            if (frac_count < 7) frac_count++;
            if (c == CH_CR) frac_blocked = 1;
         end
      end else if (!saw_point) begin
         if (is_digit(c)) begin
            if (saw_gap) begin
               field_broken = 1;
            end else begin
               next_acc = num_acc * 10 + 64'(c - CH_ZERO);
               if (next_acc > effective_limit()) field_broken = 1;
               else num_acc = next_acc;
               saw_digit = 1;
            end
         end else if (c == CH_POINT) begin
            if (!saw_digit) field_broken = 1;
            saw_point = 1;
            saw_gap = 0;
         end else begin
            field_broken = 1;
         end
      end else if (is_digit(c)) begin
         if (saw_gap || frac_blocked || frac_count >= 4) begin
            field_broken = 1;
         end else begin
            frac_count++;
            frac_acc = frac_acc * 10 + (c - CH_ZERO);
            saw_frac_digit = 1;
         end
      end else begin
         field_broken = 1;
      end
   endfunction

   function void take_side_char(logic [7:0] c, bit blank);
      int unsigned nxt;
      nxt = SM_BAD;
      if (blank) begin
         saw_gap = 1;
         return;
      end
      if (saw_gap) begin
         field_broken = 1;
         return;
      end
      case (side_state)
         SM_START: nxt = (c == "B") ? SM_B : ((c == "S") ? SM_S : SM_BAD);
         SM_B:     nxt = (c == "U") ? SM_BU : SM_BAD;
         SM_BU:    nxt = (c == "Y") ? SM_BUY : SM_BAD;
         SM_S:     nxt = (c == "E") ? SM_SE : SM_BAD;
         SM_SE:    nxt = (c == "L") ? SM_SEL : SM_BAD;
         SM_SEL:   nxt = (c == "L") ? SM_SELL : SM_BAD;
         default:  nxt = SM_BAD;
      endcase
      if (nxt == SM_BAD) field_broken = 1;
      else side_state = nxt;
   endfunction

   function void take_field_char(logic [7:0] c, bit blank);
      case (field_idx)
         F_ID:          take_integer_char(c, 0, blank);
         F_SIDE:        take_side_char(c, blank);
         F_QTY, F_TIME: take_integer_char(c, 1, blank);
         F_PRICE:       take_price_char(c, blank);
         default: ;
      endcase
   endfunction

   function void close_current_field();
      bit ok;
      int unsigned span_len;
      logic [63:0] frac, value;
      ok = !field_broken && saw_digit;
      case (field_idx)
         F_ID: id_val = num_acc;
         F_ACCOUNT, F_SYMBOL: begin
            span_len = text_last - text_first + 1;
            ok = phase == PH_TEXT;
            name_first[field_idx - 1] = (text_first > POS_MAX) ? POS_MAX : text_first;
            name_len[field_idx - 1]   = (span_len > POS_MAX) ? POS_MAX : span_len;
         end
         F_SIDE: begin
            ok = !field_broken && (side_state == SM_BUY || side_state == SM_SELL);
            line_sell = side_state == SM_SELL;
         end
         F_QTY, F_TIME: begin
            value = num_neg ? 64'd0 - num_acc : num_acc;
            if (field_idx == F_QTY) qty_val = value;
            else time_val = value;
         end
         F_PRICE: begin
            frac = '0;
            if (saw_frac_digit) begin
               frac = 64'(frac_acc);
               for (int unsigned i = frac_count; i < 4; i++) frac = frac * 10;
            end
            if (num_acc == effective_limit() && frac != 0) ok = 0;
            price_val = num_acc * 10000 + frac;
         end
         default: ;
      endcase
      if (!ok && line_error == ERR_NONE) line_error = error_of_field(field_idx);
   endfunction

   // advance the parser by one accepted transfer, returns 1 with a record
   function bit parse_transfer(bit hb, logic [7:0] c, bit eol, output result_type rec);
      bit front_blank, blank;
      rec = '0;
      if (hb) begin
         if (c == CH_COMMA) begin
            if (field_idx < F_TIME) begin
               close_current_field();
               field_idx++;
               clear_field_state();
            end else begin
               past_last_comma = 1;
            end
         end else if (!past_last_comma) begin
            front_blank = c == CH_SPACE || c == CH_TAB;
            blank = front_blank || c == CH_CR;
            if (phase == PH_LEAD) begin
               if (!front_blank) begin
                  text_first = line_pos;
                  if (blank) begin
                     phase = PH_CR;
                  end else begin
                     phase = PH_TEXT;
                     text_last = line_pos;
                  end
                  take_field_char(c, blank);
               end
            end else begin
               if (!blank) begin
                  phase = PH_TEXT;
                  text_last = line_pos;
               end
               take_field_char(c, blank);
            end
         end
         if (line_pos < POS_MAX) line_pos++;
      end
      if (!eol) return 0;
      rec.error_code = ERR_COUNT;
      if (field_idx == F_TIME && !past_last_comma) begin
         close_current_field();
         rec.error_code = line_error;
      end
      if (rec.error_code == ERR_NONE) begin
         rec.event_id       = id_val;
         rec.sell_side      = line_sell;
         rec.quantity       = qty_val;
         rec.scaled_price   = price_val[62:0];
         rec.timestamp      = time_val;
         rec.account_start  = 12'(name_first[0]);
         rec.account_length = 12'(name_len[0]);
         rec.symbol_start   = 12'(name_first[1]);
         rec.symbol_length  = 12'(name_len[1]);
      end
      clear_line_state();
      return 1;
   endfunction

   // ------------------------------------------------------------------------
   // clock, watchdog, rsp side
   // ------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CLOCK_CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // random back-pressure on records
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 6);
   end

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // compare each record transfer with the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         records_seen++;
         if (pending_records.size() == 0) begin
            report_mismatch("unexpected record", 64'(rsp_error_code), '0);
         end else begin
            want = pending_records.pop_front();
            if (rsp_error_code != want.error_code)
               report_mismatch("error_code", 64'(rsp_error_code), 64'(want.error_code));
            if (rsp_event_id != want.event_id)
               report_mismatch("event_id", rsp_event_id, want.event_id);
            if (rsp_sell_side != want.sell_side)
               report_mismatch("sell_side", 64'(rsp_sell_side), 64'(want.sell_side));
            if (rsp_quantity != want.quantity)
               report_mismatch("quantity", rsp_quantity, want.quantity);
            if (rsp_scaled_price != want.scaled_price)
               report_mismatch("scaled_price", 64'(rsp_scaled_price),
                               64'(want.scaled_price));
            if (rsp_timestamp != want.timestamp)
               report_mismatch("timestamp", rsp_timestamp, want.timestamp);
            if (rsp_account_start != want.account_start)
               report_mismatch("account_start", 64'(rsp_account_start),
                               64'(want.account_start));
            if (rsp_account_length != want.account_length)
               report_mismatch("account_length", 64'(rsp_account_length),
                               64'(want.account_length));
            if (rsp_symbol_start != want.symbol_start)
               report_mismatch("symbol_start", 64'(rsp_symbol_start),
                               64'(want.symbol_start));
            if (rsp_symbol_length != want.symbol_length)
               report_mismatch("symbol_length", 64'(rsp_symbol_length),
                               64'(want.symbol_length));
         end
      end
   end

   // ------------------------------------------------------------------------
   // req side
   // ------------------------------------------------------------------------
   // one transfer; called right after a rising edge, returns right after the
   // edge that accepted it, with valid still high
   task send_item(bit hb, logic [7:0] c, bit eol);
      result_type rec;
      if (!quiet && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_has_byte    <= hb;
      req_char_byte   <= c;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (parse_transfer(hb, c, eol, rec)) pending_records.push_back(rec);
   endtask

   // whole line, with the odd ignored idle transfer mixed in
   task send_line(byte unsigned line[$]);
      if (line.size() == 0) begin
         send_item(1'b0, 8'($urandom), 1'b1);
         return;
      end
      foreach (line[i]) begin
         if ($urandom_range(0, 99) < 3) send_item(1'b0, 8'($urandom), 1'b0);
         send_item(1'b1, line[i], i == line.size() - 1);
      end
   endtask

   // limit write, only with nothing in flight
   task write_whole_limit(logic [49:0] value);
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      whole_limit_reg = value;
   endtask

   // ------------------------------------------------------------------------
   // line builders
   // ------------------------------------------------------------------------
   function void append_text(ref byte unsigned line[$], input string s);
      for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
   endfunction

   function string blanks(bit back);
      case ($urandom_range(0, 7))
         0:       return " ";
         1:       return "\t";
         2:       return " \t ";
         3:       return back ? "\r" : "";
         default: return "";
      endcase
   endfunction

   function string random_name();
      string s;
      s = "";
      repeat ($urandom_range(1, 8)) s = {s, string'(byte'($urandom_range(65, 90)))};
      return s;
   endfunction

   function string random_signed();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return "-9223372036854775808";
         1: return "9223372036854775807";
         2: return $sformatf("%0d", $signed(64'($urandom_range(0, 999))));
         3: return $sformatf("-%0d", $urandom_range(0, 99999));
         default: return $sformatf("%0d", $signed(v));
      endcase
   endfunction

   function string random_price();
      logic [63:0] lim, whole;
      string s;
      lim = effective_limit();
      case ($urandom_range(0, 5))
         0: whole = lim;
         1: whole = 0;
         2: whole = lim + 1;
         3: whole = 64'($urandom_range(0, 5000));
         default: whole = {$urandom, $urandom} % (lim + 1);
      endcase
      s = $sformatf("%0d", whole);
      if ($urandom_range(0, 3) != 0) begin
         s = {s, "."};
         repeat ($urandom_range(0, 4)) s = {s, string'(byte'($urandom_range(48, 57)))};
      end
      return s;
   endfunction

   function string random_id();
      case ($urandom_range(0, 5))
         0: return "18446744073709551615";
         1: return "0";
         default: return $sformatf("%0d", {$urandom, $urandom});
      endcase
   endfunction

   // well-formed line with random content, optionally broken afterwards
   function void build_trade_line(ref byte unsigned line[$], input bit broken);
      string fields[7];
      int k;
      fields[F_ID]      = random_id();
      fields[F_ACCOUNT] = random_name();
      fields[F_SYMBOL]  = random_name();
      fields[F_SIDE]    = $urandom_range(0, 1) ? "SELL" : "BUY";
      fields[F_QTY]     = random_signed();
      fields[F_PRICE]   = random_price();
      fields[F_TIME]    = random_signed();
      line.delete();
      for (int f = 0; f < 7; f++) begin
         if (f != 0) line.push_back(CH_COMMA);
         append_text(line, blanks(0));
         append_text(line, fields[f]);
         append_text(line, blanks(1));
      end
      if (!broken) return;
      k = $urandom_range(0, line.size() - 1);
      case ($urandom_range(0, 3))
         0: line[k] = 8'($urandom);                  // noise byte
         1: line.insert(k, CH_COMMA);                // extra field
         2: line.delete(k);                          // missing byte
         default: line.insert(k, 8'($urandom_range(0, 255)));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task send_text(string s);
      byte unsigned line[$];
      append_text(line, s);
      send_line(line);
   endtask

   task test_directed();
      byte unsigned empty_line[$];
      send_text("1,ACC,SYM,BUY,10,12.5,100");
      send_text(" \t18446744073709551615 ,  A1 \t,B , SELL ,-9223372036854775808,0,-1\r");
      send_text("18446744073709551616,A,B,BUY,1,1,1");           // id overflow
      send_text("1, \t ,B,BUY,1,1,1");                           // empty account
      send_text("1,A,,BUY,1,1,1");                               // empty symbol
      send_text("1,A,B,BUYS,1,1,1");                             // bad side
      send_text("1,A,B,SE LL,1,1,1");                            // blank inside side
      send_text("1,A,B,BUY,9223372036854775808,1,1");            // quantity overflow
      send_text("1,A,B,BUY,-9223372036854775809,1,1");
      send_text("1,A,B,BUY,+5,1,1");                             // plus sign
      send_text("1,A,B,BUY,1,100000000,9223372036854775807");    // price at limit
      send_text("1,A,B,BUY,1,100000000.0001,1");                 // over limit fraction
      send_text("1,A,B,BUY,1,12 .3456,1");                       // blanks before point
      send_text("1,A,B,BUY,1,12. 345,1");                        // blank in fraction
      send_text("1,A,B,BUY,1,12.\r5,1");                         // cr in fraction
      send_text("1,A,B,BUY,1,12.34567,1");                       // too many digits
      send_text("1,A,B,BUY,1,.5,1");                             // no whole digits
      send_text("1,A,B,BUY,1,1,9223372036854775808");            // timestamp overflow
      send_text("1,\rAB,\r ,BUY,1 2,1,1");                       // leading cr, gap in qty
      send_text("1,A,B,BUY,1,1,1,,junk");                        // extra commas
      send_text("1,A,B,BUY,1,1");                                // missing field
      send_text("x,A,B,BUY,-,1.,1");
      send_line(empty_line);
      send_item(1'b0, 8'hFF, 1'b0);                              // idle transfer
   endtask

   task test_limit_sweep();
      logic [49:0] settings[5];
      settings = '{50'd0, WHOLE_CEILING, '1, 50'd12345, MAX_WHOLE_RESET};
      foreach (settings[i]) begin
         write_whole_limit(settings[i]);
         send_text("1,A,B,SELL,1,922337203685477.9999,1");
         send_text("1,A,B,SELL,1,0.0001,1");
      end
   endtask

   task test_long_line();
      byte unsigned line[$];
      append_text(line, "7,");
      repeat (60) line.push_back(8'h41);
      append_text(line, ",SYM,BUY,1,1,1");
      send_line(line);
   endtask

   task test_random();
      byte unsigned line[$];
      int items;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         // a stretch with no idling on either side
         quiet = items > RANDOM_ITEMS / 4 && items < 3 * RANDOM_ITEMS / 4;
         case ($urandom_range(0, 9))
            0: begin
               line.delete();
               repeat ($urandom_range(0, 20)) line.push_back(8'($urandom));
            end
            1, 2: build_trade_line(line, 1);
            default: build_trade_line(line, 0);
         endcase
         items += (line.size() == 0) ? 1 : line.size();
         send_line(line);
         if (items > RANDOM_ITEMS / 2 && items < RANDOM_ITEMS / 2 + 60)
            write_whole_limit(50'($urandom_range(1, 1000000)));
      end
      quiet = 0;
   endtask

   initial begin
      whole_limit_reg = MAX_WHOLE_RESET;
      clear_line_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_line();
      test_limit_sweep();
      test_random();
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
